>>> design/mtwb_pkg.sv
`default_nettype none
package mtwb_pkg;

    localparam int CHANNELS    = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OP_W        = 2;
    localparam int CHAN_W      = 2;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;

    localparam logic [CFG_WIDTH-1:0] DEFAULT_TIMEOUT = CFG_WIDTH'(100);

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_MESSAGE   = 2'd1;
    localparam logic [OP_W-1:0] OP_START_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP_ALL  = 2'd3;

    // one word applied to every channel in the same cycle
    typedef struct packed {
        logic            en;
        logic [OP_W-1:0] op;
    } t_step;

endpackage
`default_nettype wire

>>> design/mtwb_channel.sv
`default_nettype none
module mtwb_channel (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mtwb_pkg::t_step               i_step,
    input  wire logic                          i_sel,
    input  wire logic [mtwb_pkg::CFG_WIDTH-1:0] i_timeout,
    output logic                               o_alive_next,
    output logic                               o_expired
);
    import mtwb_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_run, n_run;
    logic                   r_alive, n_alive;

    always_comb begin
        n_cnt     = r_cnt;
        n_run     = r_run;
        n_alive   = r_alive;
        o_expired = 1'b0;
        if (i_step.en) begin
            unique case (i_step.op)
                OP_TICK: begin
                    if (r_run) begin
                        // a count of zero or one runs out on this tick
                        if (r_cnt <= COUNT_WIDTH'(1)) begin
                            n_cnt     = '0;
                            n_run     = 1'b0;
                            n_alive   = 1'b0;
                            o_expired = 1'b1;
                        end else begin
                            n_cnt = r_cnt - COUNT_WIDTH'(1);
                        end
                    end
                end
                OP_MESSAGE: begin
                    if (i_sel) begin
                        n_alive = 1'b1;
                        n_cnt   = COUNT_WIDTH'(i_timeout);
                        n_run   = 1'b1;
                    end
                end
                OP_START_ALL: begin
                    n_cnt = COUNT_WIDTH'(i_timeout);
                    n_run = 1'b1;
                end
                OP_STOP_ALL: begin
                    n_run = 1'b0;
                end
                default: begin
                    n_run = r_run;
                end
            endcase
        end
    end

    assign o_alive_next = n_alive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_run   <= 1'b0;
            r_alive <= 1'b1;
        end else begin
            r_cnt   <= n_cnt;
            r_run   <= n_run;
            r_alive <= n_alive;
        end
    end

endmodule
`default_nettype wire

>>> design/message_timeout_watchdog_bank.sv
// A word goes from the input register to the result register; all channel counters
// update in parallel in one pass, one word per cycle unless the result side stalls.
// The input side keeps taking words while a result waits, until both registers are full.
// Reset (synchronous, active low): all channels alive, all counters stopped at zero,
// timeouts back to 100 ticks, both pipeline registers empty.
`default_nettype none
module message_timeout_watchdog_bank (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [mtwb_pkg::OP_W-1:0]        i_op,
    input  wire logic [mtwb_pkg::CHAN_W-1:0]      i_channel,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [mtwb_pkg::CHANNELS-1:0]         o_alive_mask,
    output logic [mtwb_pkg::CHANNELS-1:0]         o_expired_mask,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mtwb_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [mtwb_pkg::DATA_W-1:0]      pwdata,
    output logic [mtwb_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import mtwb_pkg::*;

    logic [CFG_WIDTH-1:0] r_timeout [CHANNELS];
    logic [PADDR_W-3:0]   w_reg_idx;
    logic                 w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_timeout[i] <= DEFAULT_TIMEOUT;
            end
        end else if (w_cfg_wr) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (32'(w_reg_idx) == i) begin
                    r_timeout[i] <= pwdata[CFG_WIDTH-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (32'(w_reg_idx) == i) begin
                prdata = DATA_W'(r_timeout[i]);
            end
        end
    end

    // input register
    logic              r_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [CHAN_W-1:0] r_ch;
    logic              w_adv;
    logic              w_in_acc;

    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op <= i_op;
            r_ch <= i_channel;
        end
    end

    // channel bank
    t_step                w_step;
    logic [CHANNELS-1:0]  w_alive_next;
    logic [CHANNELS-1:0]  w_expired;

    assign w_step.en = r_in_valid && w_adv;
    assign w_step.op = r_op;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
        mtwb_channel u_ch (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (w_step),
            .i_sel        (32'(r_ch) == g),
            .i_timeout    (r_timeout[g]),
            .o_alive_next (w_alive_next[g]),
            .o_expired    (w_expired[g])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step.en) begin
            o_alive_mask   <= w_alive_next;
            o_expired_mask <= w_expired;
        end
    end

endmodule
`default_nettype wire

>>> design/mtwb_checker.sv
`default_nettype none
module mtwb_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [mtwb_pkg::CHANNELS-1:0] o_alive_mask,
    input wire logic [mtwb_pkg::CHANNELS-1:0] o_expired_mask
);
    import mtwb_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_alive_mask) && $stable(o_expired_mask))
        else $error("result word changed while stalled");

    // a channel that just expired cannot be alive in the same word
    a_exp_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_expired_mask & o_alive_mask) == '0)
        else $error("expired channel reported alive");

    // input backpressure only when a result is held up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind message_timeout_watchdog_bank mtwb_checker u_mtwb_checker (.*);
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
module tb;
    import mtwb_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 200;

    typedef struct packed {
        logic [CHANNELS-1:0] alive;
        logic [CHANNELS-1:0] expired;
    } t_mask_pair;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CHAN_W-1:0]   ch;
        logic                fixed;
        logic [CHANNELS-1:0] alive;
        logic [CHANNELS-1:0] expired;
    } t_dir_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [OP_W-1:0]     i_op = OP_TICK;
    logic [CHAN_W-1:0]   i_channel = '0;
    logic                i_out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    wire                 o_in_stall;
    wire                 o_out_valid;
    wire [CHANNELS-1:0]  o_alive_mask;
    wire [CHANNELS-1:0]  o_expired_mask;
    wire [DATA_W-1:0]    prdata;
    wire                 pready;

    // model of the watchdog bank
    logic [CHANNELS-1:0]    alive_model;
    logic [CHANNELS-1:0]    running_model;
    logic [COUNT_WIDTH-1:0] ticks_left [CHANNELS];
    logic [CFG_WIDTH-1:0]   timeout_model [CHANNELS];

    t_mask_pair pending_masks [$];
    t_dir_word  dir_words [$];
    int         mismatches = 0;
    int         results_seen = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;

    message_timeout_watchdog_bank u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alive_mask   (o_alive_mask),
        .o_expired_mask (o_expired_mask),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic watchdog_step(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                 output t_mask_pair res);
        res.expired = '0;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (running_model[i]) begin
                        // a zero load expires on the first tick, same as a load of one
                        if (ticks_left[i] <= 1) begin
                            ticks_left[i]    = '0;
                            running_model[i] = 1'b0;
                            alive_model[i]   = 1'b0;
                            res.expired[i]   = 1'b1;
                        end else begin
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        end
                    end
                end
            end
            OP_MESSAGE: begin
                if (int'(ch) < CHANNELS) begin
                    alive_model[ch]   = 1'b1;
                    ticks_left[ch]    = COUNT_WIDTH'(timeout_model[ch]);
                    running_model[ch] = 1'b1;
                end
            end
            OP_START_ALL: begin
                for (int i = 0; i < CHANNELS; i++)
                    ticks_left[i] = COUNT_WIDTH'(timeout_model[i]);
                running_model = '1;
            end
            default: begin
                running_model = '0;
            end
        endcase
        res.alive = alive_model;
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                             input logic fixed, input logic [CHANNELS-1:0] f_alive,
                             input logic [CHANNELS-1:0] f_expired);
        t_mask_pair want;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_channel  <= ch;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        watchdog_step(op, ch, want);
        if (fixed) begin
            want.alive   = f_alive;
            want.expired = f_expired;
        end
        pending_masks.push_back(want);
    endtask

    task automatic add_word(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                            input logic fixed, input logic [CHANNELS-1:0] f_alive,
                            input logic [CHANNELS-1:0] f_expired);
        t_dir_word w;
        w.op      = op;
        w.ch      = ch;
        w.fixed   = fixed;
        w.alive   = f_alive;
        w.expired = f_expired;
        dir_words.push_back(w);
    endtask

    // stop offering and let every pending word come back before touching registers
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timeout(input int idx, input logic [CFG_WIDTH-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * idx);
        // junk above bit 15 must be dropped by the register
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        timeout_model[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: checks each word and stalls in bursts or one long hold
    initial begin : result_side
        int         stall_left;
        int         hold_left;
        t_mask_pair want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                results_seen++;
                if (pending_masks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: alive %h expired %h",
                                 o_alive_mask, o_expired_mask);
                end else begin
                    want = pending_masks.pop_front();
                    if (o_alive_mask !== want.alive || o_expired_mask !== want.expired) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: alive exp %h got %h, expired exp %h got %h",
                                     results_seen, want.alive, o_alive_mask,
                                     want.expired, o_expired_mask);
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [OP_W-1:0]      op;
        logic [CFG_WIDTH-1:0] to;
        int                   pick;
        alive_model   = '1;
        running_model = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            ticks_left[i]    = '0;
            timeout_model[i] = DEFAULT_TIMEOUT;
        end

        // right after reset: nothing runs, every channel alive
        add_word(OP_TICK,      2'd0, 1'b1, 4'hF, 4'h0);
        add_word(OP_STOP_ALL,  2'd3, 1'b1, 4'hF, 4'h0);
        add_word(OP_START_ALL, 2'd1, 1'b1, 4'hF, 4'h0);
        // timeouts now 1, 0, 65535, 2
        add_word(OP_STOP_ALL,  2'd2, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd1, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd2, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd3, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd1, 1'b1, 4'hC, 4'h3);
        add_word(OP_TICK,      2'd2, 1'b1, 4'h4, 4'h8);
        add_word(OP_TICK,      2'd3, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd3, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd3, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd3, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd0, 1'b1, 4'h4, 4'h8);
        add_word(OP_START_ALL, 2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd3, 1'b1, 4'h4, 4'h3);
        add_word(OP_STOP_ALL,  2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd0, 1'b0, 4'h0, 4'h0);
        add_word(OP_MESSAGE,   2'd1, 1'b0, 4'h0, 4'h0);
        add_word(OP_TICK,      2'd2, 1'b1, 4'h4, 4'h3);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < dir_words.size(); k++) begin
            if (k == 3) begin
                drain_results();
                set_timeout(0, 16'd1);
                set_timeout(1, 16'd0);
                set_timeout(2, 16'hFFFF);
                set_timeout(3, 16'd2);
            end
            send_word(dir_words[k].op, dir_words[k].ch, dir_words[k].fixed,
                      dir_words[k].alive, dir_words[k].expired);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            if (phase == PHASES - 1)
                calm = 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                case (phase)
                    0: to = CFG_WIDTH'(3 + 2 * c);
                    1: to = CFG_WIDTH'(1 + c % 2);
                    2: to = (c == 0) ? 16'hFFFF : CFG_WIDTH'(1 << (2 * c - 2));
                    3: to = CFG_WIDTH'(5 * c);
                    default: to = CFG_WIDTH'($urandom_range(1, 4 * (phase - 2)));
                endcase
                set_timeout(c, to);
            end
            // long receiver hold while words keep coming: the block must back up
            if (phase == 1)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (phase == 4 && k == PHASE_WORDS / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    op = OP_TICK;
                else if (pick < 85)
                    op = OP_MESSAGE;
                else if (pick < 93)
                    op = OP_START_ALL;
                else
                    op = OP_STOP_ALL;
                send_word(op, CHAN_W'($urandom_range(0, 3)), 1'b0, '0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
